// ===== src/u2c_pkg.sv =====
// Shared types, constants and code point table for the UTF-8 to CP1251 stream core.
package u2c_pkg;

    // Queue between decode front and mapping back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    localparam int CPW    = 11;  // two-byte UTF-8 code point width

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       error;
        logic       last;
    } out_word_t;

    // What the front decided about one input byte
    typedef enum logic [1:0] {
        KIND_PASS,  // ASCII byte, goes out as is
        KIND_PAIR,  // completed lead + trail, code point needs mapping
        KIND_ERR,   // malformed sequence found by the front
        KIND_SKIP   // end of a string the front was dropping
    } item_kind_t;

    typedef struct packed {
        item_kind_t     kind;
        logic [CPW-1:0] data;   // byte in low bits for PASS, code point for PAIR
        logic           eos;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // CP1251 byte for a code point; zero when unmapped
    function automatic logic [7:0] map_cp(input logic [CPW-1:0] cp);
        logic [7:0] r;
        r = 8'h00;
        if (cp >= 11'h410 && cp <= 11'h44F) begin
            r = 8'(cp - 11'h350);
        end else if (cp >= 11'h402 && cp <= 11'h403) begin
            r = 8'(cp - 11'h382);
        end else begin
            case (cp)
                11'h453: r = 8'h83;  11'h409: r = 8'h8A;  11'h40A: r = 8'h8C;
                11'h40C: r = 8'h8D;  11'h40B: r = 8'h8E;  11'h40F: r = 8'h8F;
                11'h452: r = 8'h90;  11'h459: r = 8'h9A;  11'h45A: r = 8'h9C;
                11'h45C: r = 8'h9D;  11'h45B: r = 8'h9E;  11'h45F: r = 8'h9F;
                11'h0A0: r = 8'hA0;  11'h40E: r = 8'hA1;  11'h45E: r = 8'hA2;
                11'h408: r = 8'hA3;  11'h0A4: r = 8'hA4;  11'h490: r = 8'hA5;
                11'h0A6: r = 8'hA6;  11'h0A7: r = 8'hA7;  11'h0A9: r = 8'hA9;
                11'h404: r = 8'hAA;  11'h0AB: r = 8'hAB;  11'h0AC: r = 8'hAC;
                11'h0AD: r = 8'hAD;  11'h0AE: r = 8'hAE;  11'h407: r = 8'hAF;
                11'h0B0: r = 8'hB0;  11'h0B1: r = 8'hB1;  11'h406: r = 8'hB2;
                11'h456: r = 8'hB3;  11'h491: r = 8'hB4;  11'h0B5: r = 8'hB5;
                11'h0B6: r = 8'hB6;  11'h0B7: r = 8'hB7;  11'h451: r = 8'h7F;
                11'h454: r = 8'hBA;  11'h0BB: r = 8'hBB;  11'h458: r = 8'hBC;
                11'h405: r = 8'hBD;  11'h455: r = 8'hBE;  11'h457: r = 8'hBF;
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== src/u2c_front.sv =====
// Decode front: pairs lead and trail bytes, flags malformed input, drops after its own errors.
module u2c_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  u2c_pkg::in_word_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output u2c_pkg::item_t    q_item
);

    logic       lead_pending_reg, lead_pending_next;
    logic [4:0] lead_bits_reg, lead_bits_next;
    logic       discard_reg, discard_next;
    logic       accept;
    logic [7:0] b;
    logic       eos;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.in_byte;
    assign eos     = s_data.end_of_string;

    always_comb begin
        lead_pending_next = lead_pending_reg;
        lead_bits_next    = lead_bits_reg;
        discard_next      = discard_reg;
        q_push            = 1'b0;
        q_item.kind       = u2c_pkg::KIND_PASS;
        q_item.data       = {3'b000, b};
        q_item.eos        = eos;
        if (accept) begin
            if (discard_reg) begin
                // back still needs to see the string end
                if (eos) begin
                    discard_next = 1'b0;
                    q_push       = 1'b1;
                    q_item.kind  = u2c_pkg::KIND_SKIP;
                end
            end else if (lead_pending_reg) begin
                lead_pending_next = 1'b0;
                q_push            = 1'b1;
                if (b == 8'h00) begin
                    q_item.kind  = u2c_pkg::KIND_ERR;
                    discard_next = !eos;
                end else begin
                    q_item.kind = u2c_pkg::KIND_PAIR;
                    q_item.data = {lead_bits_reg, b[5:0]};
                end
            end else if (!b[7]) begin
                q_push = 1'b1;
            end else if (!b[5]) begin
                if (eos) begin
                    q_push      = 1'b1;
                    q_item.kind = u2c_pkg::KIND_ERR;
                end else begin
                    lead_pending_next = 1'b1;
                    lead_bits_next    = b[4:0];
                end
            end else begin
                q_push       = 1'b1;
                q_item.kind  = u2c_pkg::KIND_ERR;
                discard_next = !eos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_pending_reg <= 1'b0;
            lead_bits_reg    <= 5'd0;
            discard_reg      <= 1'b0;
        end else begin
            lead_pending_reg <= lead_pending_next;
            lead_bits_reg    <= lead_bits_next;
            discard_reg      <= discard_next;
        end
    end

endmodule

// ===== src/u2c_queue.sv =====
// Small register queue between decode front and mapping back.
module u2c_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  u2c_pkg::item_t      push_item,
    input  logic                pop,
    output u2c_pkg::item_t      head,
    output u2c_pkg::q_status_t  status
);

    u2c_pkg::item_t                  mem_reg [u2c_pkg::QDEPTH];
    logic [u2c_pkg::QAW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [u2c_pkg::QCW-1:0]         count_reg, count_next;

    assign status.full  = (count_reg == u2c_pkg::QCW'(u2c_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/u2c_back.sv =====
// Mapping back: code point lookup, discard after mapping errors, registered output.
module u2c_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  u2c_pkg::item_t      head,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output u2c_pkg::out_word_t  m_data
);

    logic               m_valid_reg, m_valid_next;
    u2c_pkg::out_word_t m_data_reg, m_data_next;
    logic               discard_reg, discard_next;
    logic [7:0]         mapped;

    assign q_pop   = !q_empty && (!m_valid_reg || m_ready);
    assign mapped  = u2c_pkg::map_cp(head.data);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        discard_next = discard_reg;
        if (q_pop) begin
            if (discard_reg) begin
                if (head.eos) begin
                    discard_next = 1'b0;
                end
            end else begin
                unique case (head.kind)
                    u2c_pkg::KIND_PASS: begin
                        m_valid_next         = 1'b1;
                        m_data_next.out_char = head.data[7:0];
                        m_data_next.error    = 1'b0;
                        m_data_next.last     = head.eos;
                    end
                    u2c_pkg::KIND_PAIR: begin
                        m_valid_next = 1'b1;
                        if (mapped == 8'h00) begin
                            m_data_next.out_char = 8'h00;
                            m_data_next.error    = 1'b1;
                            m_data_next.last     = 1'b1;
                            discard_next         = !head.eos;
                        end else begin
                            m_data_next.out_char = mapped;
                            m_data_next.error    = 1'b0;
                            m_data_next.last     = head.eos;
                        end
                    end
                    u2c_pkg::KIND_ERR: begin
                        // front already drops the rest of this string
                        m_valid_next         = 1'b1;
                        m_data_next.out_char = 8'h00;
                        m_data_next.error    = 1'b1;
                        m_data_next.last     = 1'b1;
                    end
                    u2c_pkg::KIND_SKIP: begin
                        m_valid_next = m_valid_reg && !m_ready;
                    end
                    default: begin
                        m_valid_next = m_valid_reg && !m_ready;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            discard_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            discard_reg <= discard_next;
        end
    end

endmodule

// ===== src/utf8_to_cp1251_stream_core.sv =====
// Top level of the UTF-8 to CP1251 stream transcoder: front, queue, back and checks.
//
// Converts a UTF-8 byte stream, one word per byte, into CP1251 bytes. ASCII
// bytes pass through; a lead byte (bit 7 set, bit 5 clear) is held and joined
// with the next byte into an 11-bit code point, which is looked up in a fixed
// table. A lead byte gives no result word on its own. Malformed input (zero
// trail byte, unmapped code point, byte with bits 7 and 5 set, lead byte at
// the end of a string) gives one result word with error=1, out_char=0 and
// last=1; the rest of that string is then dropped up to and including the
// byte flagged end_of_string. Rate: one byte per clock, sustained, as long as
// m_ready is high. An accepted byte is written into the 4-entry queue, then
// carried through the table lookup into the output register. The queue
// lets the input side keep taking bytes while a result waits on m_ready;
// s_ready drops only when the queue is full. Reset is synchronous on aresetn
// low and clears all decode state.
module utf8_to_cp1251_stream_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  u2c_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output u2c_pkg::out_word_t  m_data
);

    logic                q_push;
    logic                q_pop;
    u2c_pkg::item_t      q_in_item;
    u2c_pkg::item_t      q_head;
    u2c_pkg::q_status_t  q_status;

    // Front: byte classification and lead/trail pairing
    u2c_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_status.full),
        .q_push  (q_push),
        .q_item  (q_in_item)
    );

    // Decoupling queue
    u2c_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    // Back: table lookup and output register
    u2c_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .q_empty (q_status.empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // An error word always carries a zero char and closes the string
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |-> m_data.out_char == 8'h00 && m_data.last)
        else $error("error word with nonzero char or without last");

    // Queue never reports full and empty together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // Back only pops real entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // Front never pushes into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("push into full queue");

endmodule

// ===== tb/sv/u2c_stream_checker.sv =====
// Checker for the UTF-8 to CP1251 stream core: predicts result words and compares them.
module u2c_stream_checker
    import u2c_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_word_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_word_t  m_data,
    output int         fail_count,
    output int         outstanding,
    output int         dropped_words,
    output int         words_checked,
    output int         error_words
);

    // CP1251 byte per 11-bit code point, zero where nothing maps
    logic [7:0] cp1251_of [0:2047];

    // Decoder state kept alongside the block
    logic       lead_held;
    logic [4:0] lead_low;
    logic       skipping;

    out_word_t  awaited [$];
    out_word_t  want;

    initial begin
        for (int i = 0; i < 2048; i++) cp1251_of[i] = 8'h00;
        for (int i = 'h410; i <= 'h44F; i++) cp1251_of[i] = 8'(i - 'h350);
        cp1251_of['h402] = 8'h80;  cp1251_of['h403] = 8'h81;
        cp1251_of['h453] = 8'h83;  cp1251_of['h409] = 8'h8A;  cp1251_of['h40A] = 8'h8C;
        cp1251_of['h40C] = 8'h8D;  cp1251_of['h40B] = 8'h8E;  cp1251_of['h40F] = 8'h8F;
        cp1251_of['h452] = 8'h90;  cp1251_of['h459] = 8'h9A;  cp1251_of['h45A] = 8'h9C;
        cp1251_of['h45C] = 8'h9D;  cp1251_of['h45B] = 8'h9E;  cp1251_of['h45F] = 8'h9F;
        cp1251_of['h0A0] = 8'hA0;  cp1251_of['h40E] = 8'hA1;  cp1251_of['h45E] = 8'hA2;
        cp1251_of['h408] = 8'hA3;  cp1251_of['h0A4] = 8'hA4;  cp1251_of['h490] = 8'hA5;
        cp1251_of['h0A6] = 8'hA6;  cp1251_of['h0A7] = 8'hA7;  cp1251_of['h0A9] = 8'hA9;
        cp1251_of['h404] = 8'hAA;  cp1251_of['h0AB] = 8'hAB;  cp1251_of['h0AC] = 8'hAC;
        cp1251_of['h0AD] = 8'hAD;  cp1251_of['h0AE] = 8'hAE;  cp1251_of['h407] = 8'hAF;
        cp1251_of['h0B0] = 8'hB0;  cp1251_of['h0B1] = 8'hB1;  cp1251_of['h406] = 8'hB2;
        cp1251_of['h456] = 8'hB3;  cp1251_of['h491] = 8'hB4;  cp1251_of['h0B5] = 8'hB5;
        cp1251_of['h0B6] = 8'hB6;  cp1251_of['h0B7] = 8'hB7;  cp1251_of['h451] = 8'h7F;
        cp1251_of['h454] = 8'hBA;  cp1251_of['h0BB] = 8'hBB;  cp1251_of['h458] = 8'hBC;
        cp1251_of['h405] = 8'hBD;  cp1251_of['h455] = 8'hBE;  cp1251_of['h457] = 8'hBF;
    end

    // Bad string: one error word marked last, drop the rest unless it already ended
    task automatic flag_bad_string(input logic eos);
        lead_held = 1'b0;
        lead_low  = 5'd0;
        skipping  = !eos;
        awaited.push_back({8'h00, 1'b1, 1'b1});
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic [10:0] cp;
        logic [7:0]  ch;
        if (skipping) begin
            dropped_words++;
            if (eos) skipping = 1'b0;
        end else if (lead_held) begin
            lead_held = 1'b0;
            cp        = {lead_low, b[5:0]};
            lead_low  = 5'd0;
            ch        = cp1251_of[cp];
            if (b == 8'h00 || ch == 8'h00) flag_bad_string(eos);
            else awaited.push_back({ch, 1'b0, eos});
        end else if (!b[7]) begin
            awaited.push_back({b, 1'b0, eos});
        end else if (!b[5]) begin
            if (eos) begin
                flag_bad_string(eos);
            end else begin
                lead_held = 1'b1;
                lead_low  = b[4:0];
            end
        end else begin
            flag_bad_string(eos);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            lead_held = 1'b0;
            lead_low  = 5'd0;
            skipping  = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_checked++;
                if (m_data.error) error_words++;
                if (awaited.size() == 0) begin
                    $error("result word with nothing expected: out_char %02h error %0b last %0b",
                           m_data.out_char, m_data.error, m_data.last);
                    fail_count++;
                end else begin
                    want = awaited.pop_front();
                    if (m_data.out_char !== want.out_char) begin
                        $error("out_char: expected %02h, got %02h", want.out_char, m_data.out_char);
                        fail_count++;
                    end
                    if (m_data.error !== want.error) begin
                        $error("error: expected %0b, got %0b", want.error, m_data.error);
                        fail_count++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_data.last);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) decode_byte(s_data.in_byte, s_data.end_of_string);
        end
        outstanding = awaited.size();
    end

endmodule

// ===== tb/sv/tb_utf8_to_cp1251_stream_core.sv =====
// Testbench top for the UTF-8 to CP1251 stream core: stimulus, flow control and verdict.
module tb_utf8_to_cp1251_stream_core;
    import u2c_pkg::*;

    localparam int RANDOM_WORDS = 950;
    localparam int HOLD_CYCLES  = 300;   // receiver hold-off, far past the queue depth
    localparam int QUIET_LIMIT  = 4000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 10;    // margin after the last expected result

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    int fail_count, outstanding, dropped_words, words_checked, error_words;
    int words_sent = 0;
    int quiet_cycles = 0;

    // Shared flow-control knobs: random gaps on both sides, one long receiver hold
    logic gaps_on  = 1'b1;
    logic hold_req = 1'b0;

    utf8_to_cp1251_stream_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    u2c_stream_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .dropped_words (dropped_words),
        .words_checked (words_checked),
        .error_words   (error_words)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Offer one input word. Entered and left just after a falling edge, so
    // valid keeps a single assignment per time step: either it drops for a
    // gap or it carries the next word straight on.
    task automatic send_word(input logic [7:0] b, input logic eos);
        while (gaps_on && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {b, eos};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    // One string of random characters, end flag on its final byte. Mostly
    // clean ASCII and two-byte sequences, the rest malformed on purpose.
    task automatic send_random_string();
        int          len, sel, pick;
        logic        fin;
        logic [10:0] cp;
        logic [7:0]  lead, trail;
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
            fin  = (k == len - 1);
            pick = $urandom_range(0, 99);
            // code point mostly in the Cyrillic block, some Latin-1, some anywhere
            sel = $urandom_range(0, 99);
            if (sel < 35)      cp = 11'(11'h410 + $urandom_range(0, 63));
            else if (sel < 70) cp = 11'($urandom_range(11'h400, 11'h49F));
            else if (sel < 90) cp = 11'($urandom_range(11'h080, 11'h0BF));
            else               cp = 11'($urandom_range(0, 2047));
            // lead may be 10x or 110 on top; trail top bits usually 10
            lead  = {1'b1, 1'($urandom_range(0, 1)), 1'b0, cp[10:6]};
            trail = {2'($urandom_range(0, 3)), cp[5:0]};
            if ($urandom_range(0, 3) != 0) trail[7:6] = 2'b10;
            if (trail == 8'h00) trail = 8'h40;
            if (pick < 45) begin
                send_word(8'($urandom_range(0, 127)), fin);
            end else if (pick < 85) begin
                send_word(lead, 1'b0);
                send_word(trail, fin);
            end else if (pick < 92) begin
                send_word(8'($urandom_range(128, 255)), fin);   // any high byte
            end else if (pick < 96) begin
                send_word(lead, 1'b0);
                send_word(8'h00, fin);                          // zero trail
            end else begin
                send_word(lead, fin);                           // lead with no trail of its own
            end
        end
    endtask

    // Receiver: random ready, solid ready in the quiet stretch, and one long
    // hold-off on request while the sender keeps pushing into a full queue.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (gaps_on) begin
                m_ready <= ($urandom_range(0, 99) >= 35);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles in which no word moves on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, outstanding);
        $display("tb_utf8_to_cp1251_stream_core: errors");
        $finish;
    end

    initial begin
        int base, k;
        bit held;
        held    = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed strings: boundaries and each malformed case
        send_word(8'h00, 1'b0);                            // zero first byte passes
        send_word(8'h7F, 1'b0);                            // top of ASCII
        send_word(8'hD0, 1'b0); send_word(8'h90, 1'b0);    // U+0410, bottom of main block
        send_word(8'hD1, 1'b0); send_word(8'h8F, 1'b0);    // U+044F, top of main block
        send_word(8'hD0, 1'b0); send_word(8'h82, 1'b0);    // U+0402, small range
        send_word(8'hD1, 1'b0); send_word(8'h91, 1'b1);    // U+0451 goes to 7F here
        send_word(8'hD0, 1'b0); send_word(8'h81, 1'b0);    // U+0401 unmapped, mid string
        send_word(8'h41, 1'b0); send_word(8'h42, 1'b1);    // dropped up to end flag
        send_word(8'hC2, 1'b0); send_word(8'h00, 1'b1);    // zero trail byte
        send_word(8'hC1, 1'b0); send_word(8'h81, 1'b1);    // overlong 'A', unmapped
        send_word(8'hC2, 1'b0); send_word(8'hE0, 1'b1);    // trail top bits ignored: U+00A0
        send_word(8'hFF, 1'b1);                            // bits 7 and 5 both set
        send_word(8'hDF, 1'b1);                            // lead ends the string
        send_word(8'hE0, 1'b0); send_word(8'h80, 1'b1);    // bad byte, then dropped tail
        send_word(8'h80, 1'b0); send_word(8'hBF, 1'b1);    // 10x lead, cp 3F unmapped
        send_word(8'h41, 1'b1);

        // Random strings; a gap-free stretch in the middle, then one long stall
        base = words_sent;
        k    = 0;
        while (k < RANDOM_WORDS) begin
            gaps_on = !(k >= 250 && k < 500);
            if (!held && k >= 650) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            send_random_string();
            k = words_sent - base;
        end
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d input words accepted, %0d dropped inside bad strings", words_sent,
                 dropped_words);
        $display("%0d result words checked, %0d of them errors; one %0d-cycle output stall",
                 words_checked, error_words, HOLD_CYCLES);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_utf8_to_cp1251_stream_core: clean");
        end else begin
            $display("tb_utf8_to_cp1251_stream_core: errors");
        end
        $finish;
    end

endmodule
